[hdl/mpp_pkg.sv]
// Package for the modular power unit: field widths, modulus constants and the
// request and response structs of the modular multiplier. No dependencies.
`timescale 1ns / 1ps

package mpp_pkg;

   // Field widths of the transactions.
   localparam int BASE_W  = 30;
   localparam int EXP_W   = 31;
   localparam int POWER_W = 30;
   localparam int BIT_IDX_W = $clog2(EXP_W);

   // Operand width of the shared multiplier and its product width.
   localparam int MUL_W  = 31;
   localparam int PROD_W = 2 * MUL_W;

   // The prime modulus and the constants used by the Barrett reduction.
   localparam logic [BASE_W-1:0] MODULUS        = 30'd1000000007;
   localparam logic [31:0]       MODULUS_32     = 32'd1000000007;
   localparam logic [31:0]       TWO_MODULUS_32 = 32'd2000000014;
   localparam logic [MUL_W-1:0]  BARRETT_MU     =
      MUL_W'((64'd1 << 60) / 64'd1000000007);

   // Index of the most significant exponent bit.
   localparam logic [BIT_IDX_W-1:0] EXP_MSB = BIT_IDX_W'(EXP_W - 1);

   // Request to the modular multiplier: start pulse and two reduced operands.
   typedef struct packed {
      logic              start;
      logic [BASE_W-1:0] op_a;
      logic [BASE_W-1:0] op_b;
   } mm_req_type;

   // Response of the modular multiplier: done pulse and the reduced product.
   typedef struct packed {
      logic              done;
      logic [BASE_W-1:0] product;
   } mm_rsp_type;

endpackage

[hdl/mpp_if.sv]
// Valid/ready channel interfaces for the modular power unit.
// Depends on mpp_pkg for the field widths.
`timescale 1ns / 1ps

// Request channel: base and exponent.
interface mpp_req_if;
   logic                      valid;
   logic                      ready;
   logic [mpp_pkg::BASE_W-1:0] base;
   logic [mpp_pkg::EXP_W-1:0]  exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

// Response channel: the power.
interface mpp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mpp_pkg::POWER_W-1:0] power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface

[hdl/mpp_modmul.sv]
// Modular multiplier for the prime 1000000007: one shared 31x31 multiplier
// sequenced through product, Barrett estimate and quotient times modulus.
// Depends on mpp_pkg.
`timescale 1ns / 1ps

module mpp_modmul (
   input  logic                clock,
   input  logic                reset,
   input  mpp_pkg::mm_req_type mm_req,
   output mpp_pkg::mm_rsp_type mm_rsp
);

   localparam logic [1:0] MM_IDLE = 2'd0;
   localparam logic [1:0] MM_EST  = 2'd1;
   localparam logic [1:0] MM_QP   = 2'd2;
   localparam logic [1:0] MM_FIX  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [mpp_pkg::PROD_W-1:0]  mul_ff, mul_in;
   logic [31:0]                 low_ff, low_in;
   logic                        done_ff, done_in;
   logic [mpp_pkg::BASE_W-1:0]  result_ff, result_in;
   logic [mpp_pkg::MUL_W-1:0]   op_x, op_y;
   logic [31:0]                 rem;
   logic [32:0]                 rem_m1, rem_m2;

   // Sequencer and operand selection for the shared multiplier.
   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      op_x      = {1'b0, mm_req.op_a};
      op_y      = {1'b0, mm_req.op_b};
      rem       = low_ff - mul_ff[31:0];
      rem_m1    = {1'b0, rem} - {1'b0, mpp_pkg::MODULUS_32};
      rem_m2    = {1'b0, rem} - {1'b0, mpp_pkg::TWO_MODULUS_32};
      case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               state_in = MM_EST;
            end
         end
         MM_EST: begin
            // Keep the low product bits and estimate the quotient.
            low_in   = mul_ff[31:0];
            op_x     = mul_ff[59:29];
            op_y     = mpp_pkg::BARRETT_MU;
            state_in = MM_QP;
         end
         MM_QP: begin
            op_x     = mul_ff[61:31];
            op_y     = {1'b0, mpp_pkg::MODULUS};
            state_in = MM_FIX;
         end
         MM_FIX: begin
            // The remainder is below three times the modulus.
            if (!rem_m2[32]) begin
               result_in = rem_m2[mpp_pkg::BASE_W-1:0];
            end else if (!rem_m1[32]) begin
               result_in = rem_m1[mpp_pkg::BASE_W-1:0];
            end else begin
               result_in = rem[mpp_pkg::BASE_W-1:0];
            end
            done_in  = 1'b1;
            state_in = MM_IDLE;
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
      mul_in = {{mpp_pkg::MUL_W{1'b0}}, op_x} * {{mpp_pkg::MUL_W{1'b0}}, op_y};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mul_ff    <= mul_in;
      low_ff    <= low_in;
      result_ff <= result_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = result_ff;

endmodule

[hdl/modular_power_prime_unit.sv]
// Top level of the modular power unit: exponent bit sequencer around the
// shared modular multiplier. Depends on mpp_pkg, mpp_if and mpp_modmul.
`timescale 1ns / 1ps

// Returns base to the power exponent modulo 1000000007 by left-to-right
// square-and-multiply over all 31 exponent bits. A base at or above the
// modulus is reduced once on entry. The unit handles one transaction at a
// time: req_ch.ready is high only while idle. Every modular product runs
// through the single 31x31 multiplier in order (product, Barrett estimate,
// quotient times modulus, correction, hand-back), and a product against the
// base is skipped for zero exponent bits. The result is held on rsp_ch until
// taken.
module modular_power_prime_unit (
   input  logic      clock,
   input  logic      reset,
   mpp_req_if.sink   req_ch,
   mpp_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SQR      = 3'd1;
   localparam logic [2:0] S_SQR_WAIT = 3'd2;
   localparam logic [2:0] S_MUL      = 3'd3;
   localparam logic [2:0] S_MUL_WAIT = 3'd4;
   localparam logic [2:0] S_OUT      = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [mpp_pkg::BASE_W-1:0]      base_ff, base_in;
   logic [mpp_pkg::EXP_W-1:0]       exp_ff, exp_in;
   logic [mpp_pkg::BASE_W-1:0]      acc_ff, acc_in;
   logic [mpp_pkg::BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [mpp_pkg::BASE_W-1:0]      base_red;
   mpp_pkg::mm_req_type             mm_req;
   mpp_pkg::mm_rsp_type             mm_rsp;

   mpp_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   // One conditional subtraction fully reduces a 30-bit base.
   assign base_red = (req_ch.base >= mpp_pkg::MODULUS) ?
                     (req_ch.base - mpp_pkg::MODULUS) : req_ch.base;

   // Multiplier requests: square the accumulator or multiply by the base.
   assign mm_req.start = (state_ff == S_SQR) || (state_ff == S_MUL);
   assign mm_req.op_a  = acc_ff;
   assign mm_req.op_b  = (state_ff == S_MUL) ? base_ff : acc_ff;

   // Bit sequencer.
   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      exp_in   = exp_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               base_in  = base_red;
               exp_in   = req_ch.exponent;
               acc_in   = mpp_pkg::BASE_W'(1);
               bit_in   = mpp_pkg::EXP_MSB;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            state_in = S_SQR_WAIT;
         end
         S_SQR_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (exp_ff[bit_ff]) begin
                  state_in = S_MUL;
               end else if (bit_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_MUL: begin
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (bit_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers; the accumulator doubles as the output register.
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      bit_ff  <= bit_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign rsp_ch.power = acc_ff;

endmodule

[hdl/mpp_checker.sv]
// Port-level checker for the modular power unit and its bind statement.
// Depends on mpp_pkg and modular_power_prime_unit.
`timescale 1ns / 1ps

module mpp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mpp_pkg::POWER_W-1:0] rsp_power
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before the transaction completed");

   // The unit never takes a new transaction while a result is pending.
   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // An accepted request cannot produce its result in the very next cycle.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("unit not busy after accepting a request");

   // Once the result is taken the unit is ready again.
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("unit not ready after the result transaction");

   // Every result is fully reduced.
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_power < mpp_pkg::MODULUS))
      else $error("result not below the modulus");

endmodule

bind modular_power_prime_unit mpp_checker u_mpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_power (rsp_ch.power)
);

[sim/modular_power_prime_unit_tb.sv]
// Self-checking testbench for the modular power unit. It drives base and exponent
// transactions and checks every power against its own model of the arithmetic.
// Depends on mpp_pkg, mpp_if and the modular_power_prime_unit RTL.
`timescale 1ns / 1ps

module modular_power_prime_unit_tb;

   localparam int RANDOM_ITEMS    = 1630;
   localparam int PHASE_LEN       = 330;
   localparam int BACKPRESSURE_AT = 40;
   localparam int BACKPRESSURE_LEN = 1500;
   localparam int DRAIN_CYCLES    = 320;
   localparam int STALL_LIMIT     = 4000;
   localparam int REPORT_MAX      = 10;

   typedef struct packed {
      logic [mpp_pkg::BASE_W-1:0] base;
      logic [mpp_pkg::EXP_W-1:0]  exponent;
   } power_request_type;

   typedef enum logic [1:0] {
      PH_NO_IDLE,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   logic clock;
   logic reset;

   mpp_req_if req_if ();
   mpp_rsp_if rsp_if ();

   modular_power_prime_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   power_request_type            pending_requests[$];
   logic [mpp_pkg::POWER_W-1:0]  expected_powers[$];
   int                           requests_accepted;
   int                           powers_checked;
   int                           error_count;
   int                           unreduced_bases;
   int                           zero_exponents;
   int                           backpressure_left;
   bit                           backpressure_done;
   int                           quiet_cycles;

   // Left-to-right square-and-multiply modulo the prime, after one conditional
   // subtraction that brings a 30-bit base below the modulus.
   function automatic logic [mpp_pkg::POWER_W-1:0] power_mod_prime(
      input logic [mpp_pkg::BASE_W-1:0] base,
      input logic [mpp_pkg::EXP_W-1:0]  exponent);
      logic [63:0] reduced_base;
      logic [63:0] partial;
      int          bit_idx;
      reduced_base = 64'(base);
      if (reduced_base >= 64'(mpp_pkg::MODULUS_32)) begin
         reduced_base = reduced_base - 64'(mpp_pkg::MODULUS_32);
      end
      partial = 64'd1;
      for (bit_idx = mpp_pkg::EXP_W - 1; bit_idx >= 0; bit_idx--) begin
         partial = (partial * partial) % 64'(mpp_pkg::MODULUS_32);
         if (exponent[bit_idx]) begin
            partial = (partial * reduced_base) % 64'(mpp_pkg::MODULUS_32);
         end
      end
      return mpp_pkg::POWER_W'(partial);
   endfunction

   // Appends one transaction to the stimulus queue.
   task automatic add_request(input power_request_type item);
      pending_requests = {pending_requests, item};
   endtask

   // The handshake idling profile follows the progress of the request stream.
   function automatic idle_phase_type current_phase();
      case ((requests_accepted / PHASE_LEN) % 5)
         1: return PH_SENDER_IDLE;
         2: return PH_RECEIVER_STALL;
         3: return PH_BOTH_IDLE;
         default: return PH_NO_IDLE;
      endcase
   endfunction

   function automatic bit sender_holds_back();
      idle_phase_type phase;
      phase = current_phase();
      if (phase == PH_SENDER_IDLE) return $urandom_range(0, 99) < 77;
      if (phase == PH_BOTH_IDLE) return $urandom_range(0, 99) < 34;
      return 1'b0;
   endfunction

   function automatic bit receiver_holds_back();
      idle_phase_type phase;
      phase = current_phase();
      if (phase == PH_RECEIVER_STALL) return $urandom_range(0, 99) < 77;
      if (phase == PH_BOTH_IDLE) return $urandom_range(0, 99) < 34;
      return 1'b0;
   endfunction

   // Random request with a bias toward the interesting corners of the operands.
   function automatic power_request_type random_request();
      power_request_type req;
      int                bit_count;
      req.base     = mpp_pkg::BASE_W'($urandom());
      req.exponent = mpp_pkg::EXP_W'($urandom());
      case ($urandom_range(0, 9))
         4: req.base = mpp_pkg::BASE_W'(mpp_pkg::MODULUS_32 - 32'd3 +
                                        32'($urandom_range(0, 6)));
         5: req.exponent = mpp_pkg::EXP_W'($urandom_range(0, 40));
         6: req.base = mpp_pkg::BASE_W'($urandom_range(0, 3));
         7: begin
            // Sparse exponents keep the latency short.
            req.exponent = '0;
            bit_count = $urandom_range(1, 3);
            repeat (bit_count) req.exponent[$urandom_range(0, mpp_pkg::EXP_W - 1)] = 1'b1;
         end
         8: begin
            // Dense exponents exercise the longest multiply chains.
            req.exponent = '1;
            bit_count = $urandom_range(0, 3);
            repeat (bit_count) req.exponent[$urandom_range(0, mpp_pkg::EXP_W - 1)] = 1'b0;
         end
         9: req.base = mpp_pkg::BASE_W'({mpp_pkg::BASE_W{1'b1}} -
                                        mpp_pkg::BASE_W'($urandom_range(0, 3)));
         default: ;
      endcase
      return req;
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: offers queued transactions and records what the unit takes.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_powers = {expected_powers,
                               power_mod_prime(req_if.base, req_if.exponent)};
            requests_accepted <= requests_accepted + 1;
            if (32'(req_if.base) >= mpp_pkg::MODULUS_32) begin
               unreduced_bases <= unreduced_bases + 1;
            end
            if (req_if.exponent == '0) zero_exponents <= zero_exponents + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() > 0 && !sender_holds_back()) begin
               req_if.valid    <= 1'b1;
               req_if.base     <= pending_requests[0].base;
               req_if.exponent <= pending_requests[0].exponent;
               void'(pending_requests.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each power against the oldest expectation and
   // decides the ready level for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            powers_checked <= powers_checked + 1;
            if (expected_powers.size() == 0) begin
               if (error_count < REPORT_MAX) begin
                  $display("ERROR: unexpected power %0d with no transaction pending",
                           rsp_if.power);
               end
               error_count <= error_count + 1;
            end else begin
               if (rsp_if.power !== expected_powers[0]) begin
                  if (error_count < REPORT_MAX) begin
                     $display("ERROR: power mismatch, expected %0d, got %0d",
                              expected_powers[0], rsp_if.power);
                  end
                  error_count <= error_count + 1;
               end
               void'(expected_powers.pop_front());
            end
         end
         // One long hold-off lets the sender run into a busy unit.
         if (backpressure_left > 0) begin
            backpressure_left <= backpressure_left - 1;
            rsp_if.ready      <= 1'b0;
         end else if (!backpressure_done && requests_accepted >= BACKPRESSURE_AT) begin
            backpressure_done <= 1'b1;
            backpressure_left <= BACKPRESSURE_LEN;
            rsp_if.ready      <= 1'b0;
         end else begin
            rsp_if.ready <= !receiver_holds_back();
         end
      end
   end

   // Watchdog: a long run of cycles without any transaction means a hang.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d results still pending",
                     quiet_cycles, expected_powers.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.base       = '0;
      req_if.exponent   = '0;
      rsp_if.ready      = 1'b0;
      requests_accepted = 0;
      powers_checked    = 0;
      error_count       = 0;
      unreduced_bases   = 0;
      zero_exponents    = 0;
      backpressure_left = 0;
      backpressure_done = 1'b0;
      quiet_cycles      = 0;

      // Directed corners: zero to the zero, zero base, extreme bases and exponents,
      // bases at and above the modulus, alternating exponent bit patterns.
      add_request('{base: '0, exponent: '0});
      add_request('{base: '0, exponent: mpp_pkg::EXP_W'(1)});
      add_request('{base: '0, exponent: '1});
      add_request('{base: mpp_pkg::BASE_W'(1), exponent: '0});
      add_request('{base: mpp_pkg::BASE_W'(1), exponent: '1});
      add_request('{base: '1, exponent: '0});
      add_request('{base: '1, exponent: mpp_pkg::EXP_W'(1)});
      add_request('{base: '1, exponent: '1});
      add_request('{base: mpp_pkg::MODULUS, exponent: mpp_pkg::EXP_W'(1)});
      add_request('{base: mpp_pkg::MODULUS, exponent: '0});
      add_request('{base: mpp_pkg::MODULUS + mpp_pkg::BASE_W'(5),
                    exponent: mpp_pkg::EXP_W'(1)});
      add_request('{base: mpp_pkg::MODULUS - mpp_pkg::BASE_W'(1),
                    exponent: mpp_pkg::EXP_W'(1)});
      add_request('{base: mpp_pkg::MODULUS - mpp_pkg::BASE_W'(1),
                    exponent: mpp_pkg::EXP_W'(2)});
      add_request('{base: mpp_pkg::MODULUS - mpp_pkg::BASE_W'(1), exponent: '1});
      add_request('{base: mpp_pkg::BASE_W'(2), exponent: mpp_pkg::EXP_W'(29)});
      add_request('{base: mpp_pkg::BASE_W'(2), exponent: mpp_pkg::EXP_W'(30)});
      add_request('{base: mpp_pkg::BASE_W'(2), exponent: mpp_pkg::EXP_W'(31)});
      add_request('{base: mpp_pkg::BASE_W'(2),
                    exponent: mpp_pkg::MODULUS_32[mpp_pkg::EXP_W-1:0] -
                              mpp_pkg::EXP_W'(1)});
      add_request('{base: mpp_pkg::BASE_W'(30'h2AAAAAAA),
                    exponent: mpp_pkg::EXP_W'(31'h55555555)});
      add_request('{base: mpp_pkg::BASE_W'(30'h15555555),
                    exponent: mpp_pkg::EXP_W'(31'h2AAAAAAA)});
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_request(random_request());
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Drain: all requests taken and every expected power returned.
      while (pending_requests.size() > 0 || req_if.valid || expected_powers.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d powers from %0d transactions under four idling profiles and one",
               powers_checked, requests_accepted);
      $display("long response hold-off; %0d bases at or above the modulus, %0d zero exponents.",
               unreduced_bases, zero_exponents);
      if (error_count == 0 && expected_powers.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/mpp_pkg.sv
hdl/mpp_if.sv
hdl/mpp_modmul.sv
hdl/modular_power_prime_unit.sv
hdl/mpp_checker.sv
sim/modular_power_prime_unit_tb.sv
